@@ rtl/core/ftrm_pkg.sv @@
// Shared types, codes and constants for the fan tach rpm monitor.
package ftrm_pkg;

    // Configuration register widths and indexes
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int FREQ_W      = 20;
    localparam int CNT16_W     = 16;
    localparam int DUTY_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_TACH_FREQ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FREQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd5;

    localparam logic [FREQ_W-1:0]  RST_TACH_FREQ  = 20'd32768;
    localparam logic [CNT16_W-1:0] RST_RELOAD     = 16'd65535;
    localparam logic [CNT16_W-1:0] RST_RPM_MIN    = 16'd1000;
    localparam logic [CNT16_W-1:0] RST_RPM_MAX    = 16'd10000;
    localparam logic [FREQ_W-1:0]  RST_PWM_FREQ   = 20'd25000;
    localparam logic [CNT16_W-1:0] RST_FULL_SCALE = 16'd100;

    localparam logic [DUTY_W-1:0]  DUTY_FULL = 7'd100;

    // Serial divider: dividend holds freq * 30 (below 2^25)
    localparam int DIV_W   = FREQ_W + 5;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    // Stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // Fan status codes
    localparam logic [1:0] STAT_FRUSTRATED = 2'd0;
    localparam logic [1:0] STAT_STOPPED    = 2'd1;
    localparam logic [1:0] STAT_LOCKED     = 2'd2;

    typedef enum logic [1:0] {
        OP_SET_ENABLE = 2'd0,
        OP_SET_DUTY   = 2'd1,
        OP_SET_TARGET = 2'd2,
        OP_POLL       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_EDGE1 = 2'd1,
        PH_EDGE2 = 2'd2,
        PH_UNDER = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RPM,
        ST_DIV_TACH,
        ST_DIV_PCT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [CNT16_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/core/fan_tacho_rpm_monitor.sv @@
// Fan tach rpm monitor top level: command decode, measurement phases, result beat.
//
//  channel   direction  bits              contents
//  s_*       in         tuser 2, tdata 48 one command beat
//  m_*       out        tdata 48          one result beat per command
//  cfg_*     in         idx 3, data 20    register write, no read-back
//
// Set enable, set duty and polls that need no division go from accept straight
// to the emit step, which loads the result beat into the output register. A
// poll that measures an interval first runs the shared divider, and set rpm
// target runs it twice, once for the tach value and once for the percentage;
// the divider produces one quotient bit per cycle over 25 bits. One command is
// in flight at a time; the next beat is taken while a result waits in the output
// register, and a stalled result holds the next command in its emit step.
// Reset loads register defaults and fan and control state, not the result payload.
module fan_tacho_rpm_monitor
    import ftrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] enable_value, [7:1] duty_percent, [23:8] target_rpm,
    // [24] capture_pending, [25] underflow_pending, [41:26] captured_count
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] rpm_now, [17:16] status, [18] stalled,
    // [25:19] duty_now, [41:26] target_now
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [FREQ_W-1:0]  tach_freq_reg;
    logic [CNT16_W-1:0] reload_reg;
    logic [CNT16_W-1:0] rpm_min_reg;
    logic [CNT16_W-1:0] rpm_max_reg;
    logic [FREQ_W-1:0]  pwm_freq_reg;
    logic [CNT16_W-1:0] full_scale_reg;

    // Fan state
    state_t             state_reg,   state_next;
    phase_t             phase_reg,   phase_next;
    logic [CNT16_W-1:0] rpm_reg,     rpm_next;
    logic               never_reg,   never_next;
    logic               working_reg, working_next;
    logic               enabled_reg, enabled_next;
    logic [DUTY_W-1:0]  duty_reg,    duty_next;
    logic [CNT16_W-1:0] target_reg,  target_next;

    // Output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    // Divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Unpacked command fields
    op_t                op;
    logic               enable_value;
    logic [DUTY_W-1:0]  duty_percent;
    logic [CNT16_W-1:0] target_rpm;
    logic               capture_pending;
    logic               underflow_pending;
    logic [CNT16_W-1:0] captured_count;

    logic               accept;
    logic               out_free;
    logic               measuring;
    logic               need_rpm_div;
    logic [CNT16_W-1:0] fs_eff;
    logic [CNT16_W-1:0] tach_clip;
    logic [DIV_W-1:0]   tach_x30;
    logic [DIV_W-1:0]   pwm_x30;
    logic               frustrated;
    logic [1:0]         status_code;
    logic               stalled;

    assign op                = op_t'(s_tuser[1:0]);
    assign enable_value      = s_tdata[0];
    assign duty_percent      = s_tdata[7:1];
    assign target_rpm        = s_tdata[23:8];
    assign capture_pending   = s_tdata[24];
    assign underflow_pending = s_tdata[25];
    assign captured_count    = s_tdata[41:26];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // x*30 as x*32 - x*2
    assign tach_x30 = {tach_freq_reg, 5'b0} - DIV_W'({tach_freq_reg, 1'b0});
    assign pwm_x30  = {pwm_freq_reg, 5'b0} - DIV_W'({pwm_freq_reg, 1'b0});

    // zero full scale counts as one
    assign fs_eff = (full_scale_reg == '0) ? CNT16_W'(1) : full_scale_reg;

    // clip the tach value at full scale
    assign tach_clip = (div_rsp.quotient > DIV_W'(fs_eff)) ? fs_eff
                                                           : div_rsp.quotient[CNT16_W-1:0];

    assign measuring = working_reg && enabled_reg && (duty_reg != '0);

    // a capture in phase PH_EDGE2 over a nonempty interval needs the divider
    assign need_rpm_div = (op == OP_POLL) && measuring && (phase_reg == PH_EDGE2) &&
                          !underflow_pending && capture_pending &&
                          (captured_count < reload_reg);

    // Status from state after the command
    assign frustrated = (working_reg == (rpm_reg == '0));
    assign stalled    = enabled_reg && frustrated;

    always_comb
    begin
        if (frustrated)
            status_code = STAT_FRUSTRATED;
        else if (!working_reg)
            status_code = STAT_STOPPED;
        else
            status_code = STAT_LOCKED;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_SET_TARGET)
                        state_next = ST_DIV_TACH;
                    else if (need_rpm_div)
                        state_next = ST_DIV_RPM;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_DIV_RPM:
            begin
                if (div_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_DIV_TACH:
            begin
                if (div_rsp.done)
                    state_next = ST_DIV_PCT;
            end
            ST_DIV_PCT:
            begin
                if (div_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        phase_next       = phase_reg;
        rpm_next         = rpm_reg;
        never_next       = never_reg;
        working_next     = working_reg;
        enabled_next     = enabled_reg;
        duty_next        = duty_reg;
        target_next      = target_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        div_req.start    = 1'b0;
        div_req.dividend = tach_x30;
        div_req.divisor  = reload_reg - captured_count;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_SET_ENABLE:
                        begin
                            enabled_next = enable_value;
                        end
                        OP_SET_DUTY:
                        begin
                            duty_next    = (duty_percent > DUTY_FULL) ? DUTY_FULL
                                                                      : duty_percent;
                            working_next = (duty_percent != '0);
                        end
                        OP_SET_TARGET:
                        begin
                            target_next      = target_rpm;
                            div_req.start    = 1'b1;
                            div_req.dividend = pwm_x30;
                            div_req.divisor  = (target_rpm == '0) ? CNT16_W'(1)
                                                                  : target_rpm;
                        end
                        OP_POLL:
                        begin
                            if (!measuring)
                            begin
                                // preset and drop back to idle
                                rpm_next   = enabled_reg ? rpm_min_reg : '0;
                                never_next = 1'b0;
                                phase_next = PH_IDLE;
                            end
                            else if (phase_reg == PH_IDLE)
                            begin
                                // seed, ignore pending flags on this poll
                                if ((rpm_reg == '0) || never_reg)
                                begin
                                    rpm_next   = rpm_min_reg;
                                    never_next = 1'b0;
                                end
                                phase_next = PH_EDGE1;
                            end
                            else if (underflow_pending)
                            begin
                                rpm_next   = rpm_max_reg;
                                never_next = 1'b0;
                                phase_next = PH_UNDER;
                            end
                            else if (capture_pending)
                            begin
                                if (phase_reg == PH_EDGE1)
                                    phase_next = PH_EDGE2;
                                else if (phase_reg == PH_EDGE2)
                                begin
                                    if (need_rpm_div)
                                        div_req.start = 1'b1;
                                    else
                                    begin
                                        // empty interval reads as zero rpm
                                        rpm_next   = '0;
                                        never_next = 1'b0;
                                        phase_next = PH_IDLE;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            enabled_next = enabled_reg;
                        end
                    endcase
                end
            end
            ST_DIV_RPM:
            begin
                if (div_rsp.done)
                begin
                    // saturate at 16 bits
                    rpm_next   = (div_rsp.quotient[DIV_W-1:CNT16_W] != '0)
                               ? '1 : div_rsp.quotient[CNT16_W-1:0];
                    never_next = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
            ST_DIV_TACH:
            begin
                if (div_rsp.done)
                begin
                    // tach * 100 = tach*64 + tach*32 + tach*4
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({tach_clip, 6'b0}) +
                                       DIV_W'({tach_clip, 5'b0}) +
                                       DIV_W'({tach_clip, 2'b0});
                    div_req.divisor  = fs_eff;
                end
            end
            ST_DIV_PCT:
            begin
                if (div_rsp.done)
                begin
                    // percentage never exceeds 100 since tach is clipped
                    duty_next    = DUTY_FULL - div_rsp.quotient[DUTY_W-1:0];
                    working_next = (div_rsp.quotient[DUTY_W-1:0] != DUTY_FULL);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, target_reg, duty_reg, stalled,
                                     status_code, rpm_reg};
                end
            end
            default:
            begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    ftrm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tach_freq_reg  <= RST_TACH_FREQ;
            reload_reg     <= RST_RELOAD;
            rpm_min_reg    <= RST_RPM_MIN;
            rpm_max_reg    <= RST_RPM_MAX;
            pwm_freq_reg   <= RST_PWM_FREQ;
            full_scale_reg <= RST_FULL_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TACH_FREQ:  tach_freq_reg  <= cfg_data[FREQ_W-1:0];
                CFG_RELOAD:     reload_reg     <= cfg_data[CNT16_W-1:0];
                CFG_RPM_MIN:    rpm_min_reg    <= cfg_data[CNT16_W-1:0];
                CFG_RPM_MAX:    rpm_max_reg    <= cfg_data[CNT16_W-1:0];
                CFG_PWM_FREQ:   pwm_freq_reg   <= cfg_data[FREQ_W-1:0];
                CFG_FULL_SCALE: full_scale_reg <= cfg_data[CNT16_W-1:0];
                default:        full_scale_reg <= full_scale_reg;
            endcase
        end
    end

    // Control and fan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_IDLE;
            rpm_reg      <= '0;
            never_reg    <= 1'b1;
            working_reg  <= 1'b0;
            enabled_reg  <= 1'b0;
            duty_reg     <= '0;
            target_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            rpm_reg      <= rpm_next;
            never_reg    <= never_next;
            working_reg  <= working_next;
            enabled_reg  <= enabled_next;
            duty_reg     <= duty_next;
            target_reg   <= target_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The divider only finishes while a division is awaited
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_RPM || state_reg == ST_DIV_TACH ||
                          state_reg == ST_DIV_PCT))
        else $error("divider finished outside a divide state");

    // Stored duty stays within percent range
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_FULL)
        else $error("duty above 100 percent");

    // A new result beat is only raised from the emit state
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |-> $past(state_reg == ST_EMIT))
        else $error("result beat loaded outside emit state");

    // Working flag always agrees with a nonzero duty
    a_working_duty: assert property (@(posedge clk) disable iff (!rst_n)
        working_reg == (duty_reg != '0))
        else $error("working flag out of step with duty");

endmodule

@@ rtl/core/ftrm_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module ftrm_div
    import ftrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DCNT_W-1:0]  cnt_reg,  cnt_next;
    logic               done_reg, done_next;
    logic [DIV_W-1:0]   dvd_reg,  dvd_next;
    logic [CNT16_W-1:0] rem_reg,  rem_next;
    logic [CNT16_W-1:0] dsr_reg,  dsr_next;
    logic [CNT16_W:0]   trial;
    logic [CNT16_W:0]   diff;
    logic               ge;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            cnt_next = DCNT_W'(DIV_W);
            dvd_next = req.dividend;
            dsr_next = req.divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in one dividend bit, subtract when it fits
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_W'(1));
            dvd_next  = {dvd_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[CNT16_W-1:0] : trial[CNT16_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the fan tach rpm monitor: command stream in, status beats out.
module tb
    import ftrm_pkg::*;
();

    localparam int unsigned TACH_TO_RPM  = 30;   // tach edges per revolution folded with 60 s
    localparam int unsigned PCT_FULL     = 100;
    localparam int unsigned RPM_CEIL     = 65535;
    localparam int unsigned QUIET_LIMIT  = 4000; // cycles with no beat moving on either side
    localparam int unsigned TAIL_CYCLES  = 60;   // longest command is set rpm target
    localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int unsigned BURST_ITEMS  = 300;

    // One command beat, fields as the block sees them
    typedef struct packed {
        op_t         op;
        logic        en;
        logic [6:0]  duty;
        logic [15:0] target;
        logic        cap;
        logic        und;
        logic [15:0] captured;
    } fan_cmd_t;

    // One status beat
    typedef struct packed {
        logic [15:0] rpm;
        logic [1:0]  status;
        logic        stall;
        logic [6:0]  duty;
        logic [15:0] target;
    } result_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    fan_tacho_rpm_monitor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file
    logic [19:0] tach_hz    = RST_TACH_FREQ;
    logic [15:0] reload_cnt = RST_RELOAD;
    logic [15:0] floor_rpm  = RST_RPM_MIN;
    logic [15:0] ceil_rpm   = RST_RPM_MAX;
    logic [19:0] pwm_hz     = RST_PWM_FREQ;
    logic [15:0] full_scale = RST_FULL_SCALE;

    // Shadow copy of the fan state
    phase_t      meas_phase   = PH_IDLE;
    logic [15:0] fan_rpm      = '0;
    logic        unmeasured   = 1'b1;
    logic        fan_spinning = 1'b0;
    logic        fan_enabled  = 1'b0;
    logic [6:0]  fan_duty     = '0;
    logic [15:0] fan_target   = '0;

    fan_cmd_t     cmd_q[$];          // commands waiting for the driver
    result_beat_t status_expect_q[$]; // predicted beats, oldest first
    fan_cmd_t     live_cmd;

    int unsigned cmds_issued     = 0;
    int unsigned beats_checked   = 0;
    int unsigned mismatch_count  = 0;
    int unsigned poll_count      = 0;
    int unsigned reading_count   = 0;
    int unsigned underflow_count = 0;
    int unsigned settings_count  = 0;
    int unsigned send_idle_pct   = 13;
    int unsigned recv_idle_pct   = 60;
    logic        hold_request    = 1'b0;

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // Advance the shadow fan state by one command and return the beat it should produce.
    function automatic result_beat_t advance_fan_model(fan_cmd_t c);
        result_beat_t r;
        logic [6:0]  d;
        int unsigned fs;
        int unsigned div;
        int unsigned tach;
        int unsigned pct;
        int unsigned reading;
        case (c.op)
            OP_SET_ENABLE:
                fan_enabled = c.en;
            OP_SET_DUTY:
            begin
                // clamp anything above full duty
                d = (c.duty > DUTY_FULL) ? DUTY_FULL : c.duty;
                fan_duty = d;
                fan_spinning = (d != 0);
            end
            OP_SET_TARGET:
            begin
                // zero full scale counts as one pulse, zero rpm as one rpm
                fs = (full_scale != 0) ? full_scale : 1;
                div = (c.target != 0) ? c.target : 1;
                tach = (pwm_hz * TACH_TO_RPM) / div;
                if (tach > fs)
                    tach = fs;
                pct = (tach * PCT_FULL) / fs;
                if (pct > PCT_FULL)
                    pct = PCT_FULL;
                fan_target = c.target;
                fan_duty = 7'(PCT_FULL - pct);
                fan_spinning = (fan_duty != 0);
            end
            default:
            begin
                poll_count++;
                if (fan_spinning && fan_enabled && fan_duty != 0) begin
                    if (meas_phase == PH_IDLE) begin
                        // seed the reading; pending flags on this poll are dropped
                        if (fan_rpm == 0 || unmeasured) begin
                            fan_rpm = floor_rpm;
                            unmeasured = 1'b0;
                        end
                        meas_phase = PH_EDGE1;
                    end else if (c.und) begin
                        // underflow wins over a capture and sticks
                        fan_rpm = ceil_rpm;
                        unmeasured = 1'b0;
                        meas_phase = PH_UNDER;
                        underflow_count++;
                    end else if (c.cap) begin
                        if (meas_phase == PH_EDGE1) begin
                            meas_phase = PH_EDGE2;
                        end else if (meas_phase == PH_EDGE2) begin
                            reading = 0;
                            if (c.captured < reload_cnt) begin
                                reading = (tach_hz * TACH_TO_RPM) / (reload_cnt - c.captured);
                                if (reading > RPM_CEIL)
                                    reading = RPM_CEIL;
                            end
                            fan_rpm = reading[15:0];
                            unmeasured = 1'b0;
                            meas_phase = PH_IDLE;
                            reading_count++;
                        end
                    end
                end else begin
                    fan_rpm = fan_enabled ? floor_rpm : 16'd0;
                    unmeasured = 1'b0;
                    meas_phase = PH_IDLE;
                end
            end
        endcase

        if ((fan_spinning && fan_rpm == 0) || (!fan_spinning && fan_rpm != 0))
            r.status = STAT_FRUSTRATED;
        else if (fan_rpm == 0 && !fan_spinning)
            r.status = STAT_STOPPED;
        else
            r.status = STAT_LOCKED;
        r.stall = fan_enabled && !((fan_spinning && fan_rpm != 0) ||
                                   (!fan_spinning && fan_rpm == 0));
        r.rpm = fan_rpm;
        r.duty = fan_duty;
        r.target = fan_target;
        return r;
    endfunction

    // Driver: advance the beat on acceptance, predict its result, fetch the next one.
    always @(posedge clk or negedge rst_n) begin : drive_commands
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end else begin
            if (s_tvalid && s_tready)
                status_expect_q.push_back(advance_fan_model(live_cmd));
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    live_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= live_cmd.op;
                    s_tdata <= {6'd0, live_cmd.captured, live_cmd.und, live_cmd.cap,
                                live_cmd.target, live_cmd.duty, live_cmd.en};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted status beat, then decide the next ready level.
    always @(posedge clk or negedge rst_n) begin : watch_status
        result_beat_t want;
        int unsigned  hold_left;
        logic         hold_done;
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_expect_q.size() == 0) begin
                    report_mismatch("unrequested beat, rpm_now", 0, m_tdata[15:0]);
                end else begin
                    want = status_expect_q.pop_front();
                    if (m_tdata[15:0] !== want.rpm)
                        report_mismatch("rpm_now", want.rpm, m_tdata[15:0]);
                    if (m_tdata[17:16] !== want.status)
                        report_mismatch("status", want.status, m_tdata[17:16]);
                    if (m_tdata[18] !== want.stall)
                        report_mismatch("stalled", want.stall, m_tdata[18]);
                    if (m_tdata[25:19] !== want.duty)
                        report_mismatch("duty_now", want.duty, m_tdata[25:19]);
                    if (m_tdata[41:26] !== want.target)
                        report_mismatch("target_now", want.target, m_tdata[41:26]);
                end
                beats_checked++;
            end
            // one long hold-off on request, otherwise random stalls
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge clk) begin : watchdog
        int unsigned quiet_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d of %0d results seen",
                     $time, QUIET_LIMIT, beats_checked, cmds_issued);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic post(op_t op, logic en, logic [6:0] duty, logic [15:0] tgt,
                        logic cap, logic und, logic [15:0] cnt);
        fan_cmd_t c;
        c.op = op;
        c.en = en;
        c.duty = duty;
        c.target = tgt;
        c.cap = cap;
        c.und = und;
        c.captured = cnt;
        cmd_q.push_back(c);
        cmds_issued++;
    endtask

    // Write one register at a clock edge and mirror it in the shadow copy.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        case (idx)
            CFG_TACH_FREQ:  tach_hz = 20'(value);
            CFG_RELOAD:     reload_cnt = 16'(value);
            CFG_RPM_MIN:    floor_rpm = 16'(value);
            CFG_RPM_MAX:    ceil_rpm = 16'(value);
            CFG_PWM_FREQ:   pwm_hz = 20'(value);
            CFG_FULL_SCALE: full_scale = 16'(value);
            default: ;
        endcase
    endtask

    task automatic load_settings(int unsigned t, int unsigned rl, int unsigned mn,
                                 int unsigned mx, int unsigned p, int unsigned fs);
        cfg_write(CFG_TACH_FREQ, t);
        cfg_write(CFG_RELOAD, rl);
        cfg_write(CFG_RPM_MIN, mn);
        cfg_write(CFG_RPM_MAX, mx);
        cfg_write(CFG_PWM_FREQ, p);
        cfg_write(CFG_FULL_SCALE, fs);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Hold until every command issued so far has produced its checked beat.
    task automatic wait_drained();
        while (beats_checked < cmds_issued)
            @(posedge clk);
    endtask

    // Mostly well-formed measurement runs with random content, the rest noise.
    task automatic queue_random_burst(int unsigned n);
        int unsigned first;
        int unsigned off;
        int unsigned tmp;
        logic [15:0] cnt;
        first = cmds_issued;
        while (cmds_issued - first < n) begin
            if ($urandom_range(0, 3) == 0) begin
                post(op_t'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom_range(0, 127),
                     $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 65535));
            end else begin
                post(OP_SET_ENABLE, $urandom_range(0, 9) != 0, $urandom_range(0, 127),
                     $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 65535));
                if ($urandom_range(0, 2) == 0)
                    post(OP_SET_TARGET, $urandom_range(0, 1), $urandom_range(0, 127),
                         $urandom_range(0, 65535), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 65535));
                else
                    post(OP_SET_DUTY, $urandom_range(0, 1),
                         ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127),
                         $urandom_range(0, 65535), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 65535));
                repeat ($urandom_range(2, 8)) begin
                    // aim the capture near the reload value to hit saturation and empty intervals
                    off = $urandom_range(0, 40);
                    case ($urandom_range(0, 3))
                        0: cnt = $urandom_range(0, 65535);
                        1: cnt = (reload_cnt > off) ? reload_cnt - off - 1 : 16'd0;
                        2:
                        begin
                            tmp = reload_cnt + (off % 4);
                            cnt = (tmp > RPM_CEIL) ? 16'hFFFF : tmp[15:0];
                        end
                        default: cnt = $urandom_range(0, 255);
                    endcase
                    post(OP_POLL, $urandom_range(0, 1), $urandom_range(0, 127),
                         $urandom_range(0, 65535), $urandom_range(0, 9) < 7,
                         $urandom_range(0, 9) == 0, cnt);
                end
            end
        end
    endtask

    initial begin : stimulus
        int unsigned chunk;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset register values
        post(OP_POLL,       0, 0,   0,      0, 0, 16'h0000); // disabled, stopped
        post(OP_SET_ENABLE, 1, 0,   0,      0, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      1, 1, 16'hFFFF); // enabled, not working: floor rpm
        post(OP_SET_DUTY,   0, 127, 0,      0, 0, 16'h0000); // saturates at full duty
        post(OP_SET_DUTY,   0, 0,   0,      0, 0, 16'h0000);
        post(OP_SET_DUTY,   0, 100, 0,      0, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      1, 1, 16'h0000); // idle: flags dropped
        post(OP_POLL,       0, 0,   0,      1, 0, 16'h0000); // first edge
        post(OP_POLL,       0, 0,   0,      1, 1, 16'h0000); // underflow beats capture
        post(OP_POLL,       0, 0,   0,      1, 0, 16'h1234); // sticky underflow
        post(OP_SET_DUTY,   0, 0,   0,      0, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      0, 0, 16'h0000); // back to idle at floor rpm
        post(OP_SET_DUTY,   1, 50,  16'hFFFF, 0, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      0, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      1, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      1, 0, 16'hFFFF); // capture at reload: rpm 0
        post(OP_POLL,       0, 0,   0,      0, 0, 16'h0000); // reseed after zero rpm
        post(OP_POLL,       0, 0,   0,      1, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      1, 0, 16'hFFFE); // one-count interval saturates
        post(OP_POLL,       0, 0,   0,      0, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      1, 0, 16'h0000);
        post(OP_POLL,       0, 0,   0,      1, 0, 16'h0000); // longest interval
        post(OP_SET_TARGET, 0, 0,   16'h0000, 0, 0, 16'h0000);
        post(OP_SET_TARGET, 0, 0,   16'hFFFF, 0, 0, 16'h0000);
        post(OP_SET_ENABLE, 0, 0,   0,      0, 0, 16'h0000);
        post(OP_POLL,       1, 127, 16'hFFFF, 1, 1, 16'hFFFF);
        wait_drained();

        // Random part: six register settings, three idling patterns
        for (chunk = 0; chunk < 6; chunk++) begin
            send_idle_pct = (chunk < 2) ? 13 : (chunk < 4) ? 60 : 0;
            recv_idle_pct = (chunk < 2) ? 60 : (chunk < 4) ? 13 : 0;
            case (chunk)
                0: load_settings(32'(RST_TACH_FREQ), 32'(RST_RELOAD), 32'(RST_RPM_MIN),
                                 32'(RST_RPM_MAX), 32'(RST_PWM_FREQ), 32'(RST_FULL_SCALE));
                1: load_settings(1000000, 65535, 65535, 65535, 1000000, 65535);
                2: load_settings(1, 1, 0, 0, 1, 1);
                // zero tach clock and zero full scale
                3: load_settings(0, $urandom_range(1, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(1, 1000000), 0);
                default: load_settings($urandom_range(1, 1000000), $urandom_range(1, 65535),
                                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                                       $urandom_range(1, 1000000), $urandom_range(1, 65535));
            endcase
            // with the sender never idling, hold off the receiver so the block backs up
            if (chunk == 4)
                hold_request = 1'b1;
            queue_random_burst(BURST_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (status_expect_q.size() != 0)
            report_mismatch("results never delivered", 0, status_expect_q.size());

        $display("Covered %0d commands (%0d polls) under %0d register settings plus reset values.",
                 cmds_issued, poll_count, settings_count);
        $display("Completed %0d speed readings and %0d timer underflows; %0d mismatches.",
                 reading_count, underflow_count, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
